// ----- hdl/ecev_pkg.sv -----
// ----------------------------------------------------------------------------
// ecev_pkg
// Shared types, codes and the sine table generator for the easing evaluator.
// ----------------------------------------------------------------------------
package ecev_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT    = 16;
  localparam int unsigned SINE_ENTRIES_DEFAULT = 1024;
  localparam int unsigned OP_W                 = 4;

  // pi/2 in Q30
  localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

  typedef enum logic [OP_W-1:0] {
    OP_LINEAR       = 4'd0,
    OP_IN           = 4'd1,
    OP_OUT          = 4'd2,
    OP_INOUT        = 4'd3,
    OP_QUAD_IN      = 4'd4,
    OP_QUAD_OUT     = 4'd5,
    OP_QUAD_INOUT   = 4'd6,
    OP_CUBIC_IN     = 4'd7,
    OP_CUBIC_OUT    = 4'd8,
    OP_CUBIC_INOUT  = 4'd9,
    OP_SINE_IN      = 4'd10,
    OP_SINE_OUT     = 4'd11,
    OP_SINE_INOUT   = 4'd12,
    OP_BOUNCE_IN    = 4'd13,
    OP_BOUNCE_OUT   = 4'd14,
    OP_BOUNCE_INOUT = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    KIND_LINEAR,
    KIND_POLY,
    KIND_SINE,
    KIND_BOUNCE
  } kind_e;

  // bounce parabola segment
  typedef enum logic [1:0] {
    SEG_0,
    SEG_1,
    SEG_2,
    SEG_3
  } seg_e;

  // final combine: r = (add_one ? 1 : 0) +/- (v << shl), then optional halve
  typedef struct packed {
    kind_e      kind;
    logic       cubic;
    logic       add_one;
    logic       negate;
    logic [1:0] shl;
    logic       halve;
  } ctl_t;

  // sin(ang) for ang in Q30, Taylor series, rounded to frac_bits (elaboration only)
  function automatic logic [63:0] sine_entry(logic [63:0] ang, int unsigned frac_bits);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    a2   = (ang * ang + (64'd1 << 29)) >> 30;
    term = ang;
    sum  = longint'(ang);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * a2 + (64'd1 << 29)) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * (64'd1 << frac_bits) + (64'd1 << 29)) >> 30;
    if (v > (64'd1 << frac_bits)) begin
      v = 64'd1 << frac_bits;
    end
    return v;
  endfunction

endpackage

// ----- hdl/easing_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// Fixed-point easing curves (linear, quad, cubic, sine, bounce), one item
// per clock.
//
//   channel   handshake          payload
//   input     start / busy       op_i, progress_i
//   result    done_o (strobe)    eased_o
//
// One item per cycle; the result strobe on done_o comes from the output register.
// The pipeline has seven register stages: capture, decode, sine ROM read,
// shared multiplier, round, cube multiplier, output register.
// Reset clears the valid bits only; the sine table is constant logic.
// busy is always low; results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module easing_curve_evaluator #(
  parameter int unsigned FRAC_BITS    = ecev_pkg::FRAC_BITS_DEFAULT,
  parameter int unsigned SINE_ENTRIES = ecev_pkg::SINE_ENTRIES_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ecev_pkg::OP_W-1:0]  op_i,
  input  logic [FRAC_BITS:0]         progress_i,
  output logic                       done_o,
  output logic [FRAC_BITS:0]         eased_o
);
  import ecev_pkg::*;

  localparam int unsigned EAW = $clog2(SINE_ENTRIES / 2 + 1);
  localparam int unsigned OAW = $clog2((SINE_ENTRIES + 1) / 2);

  logic                 fr_valid;
  ctl_t                 fr_ctl;
  logic [FRAC_BITS:0]   fr_x;
  logic [FRAC_BITS-1:0] fr_frac;
  logic                 fr_odd_lo;
  logic [EAW-1:0]       fr_even_addr;
  logic [OAW-1:0]       fr_odd_addr;
  logic [FRAC_BITS+1:0] fr_dabs;
  seg_e                 fr_seg;
  logic [FRAC_BITS:0]   rom_even;
  logic [FRAC_BITS:0]   rom_odd;

  assign busy = 1'b0;

  ecev_front #(
    .FRAC_BITS    (FRAC_BITS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .op_i        (op_i),
    .progress_i  (progress_i),
    .valid_o     (fr_valid),
    .ctl_o       (fr_ctl),
    .x_o         (fr_x),
    .frac_o      (fr_frac),
    .odd_lo_o    (fr_odd_lo),
    .even_addr_o (fr_even_addr),
    .odd_addr_o  (fr_odd_addr),
    .dabs_o      (fr_dabs),
    .seg_o       (fr_seg)
  );

  ecev_sine_rom #(
    .FRAC_BITS    (FRAC_BITS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine_rom (
    .clk_i       (clk_i),
    .even_addr_i (fr_even_addr),
    .odd_addr_i  (fr_odd_addr),
    .even_data_o (rom_even),
    .odd_data_o  (rom_odd)
  );

  ecev_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fr_valid),
    .ctl_i       (fr_ctl),
    .x_i         (fr_x),
    .frac_i      (fr_frac),
    .odd_lo_i    (fr_odd_lo),
    .dabs_i      (fr_dabs),
    .seg_i       (fr_seg),
    .even_data_i (rom_even),
    .odd_data_i  (rom_odd),
    .valid_o     (done_o),
    .eased_o     (eased_o)
  );

endmodule

// ----- hdl/ecev_front.sv -----
// ----------------------------------------------------------------------------
// ecev_front
// Input capture, saturation, curve decode, operand select, sine table index
// and bounce segment split. Two register stages.
// ----------------------------------------------------------------------------
module ecev_front #(
  parameter int unsigned FRAC_BITS    = ecev_pkg::FRAC_BITS_DEFAULT,
  parameter int unsigned SINE_ENTRIES = ecev_pkg::SINE_ENTRIES_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [ecev_pkg::OP_W-1:0]              op_i,
  input  logic [FRAC_BITS:0]                     progress_i,
  output logic                                   valid_o,
  output ecev_pkg::ctl_t                         ctl_o,
  output logic [FRAC_BITS:0]                     x_o,
  output logic [FRAC_BITS-1:0]                   frac_o,
  output logic                                   odd_lo_o,
  output logic [$clog2(SINE_ENTRIES/2+1)-1:0]    even_addr_o,
  output logic [$clog2((SINE_ENTRIES+1)/2)-1:0]  odd_addr_o,
  output logic [FRAC_BITS+1:0]                   dabs_o,
  output ecev_pkg::seg_e                         seg_o
);
  import ecev_pkg::*;

  localparam int unsigned NE  = SINE_ENTRIES / 2 + 1;
  localparam int unsigned NO  = (SINE_ENTRIES + 1) / 2;
  localparam int unsigned EAW = $clog2(NE);
  localparam int unsigned OAW = $clog2(NO);
  localparam int unsigned IXW = $clog2(SINE_ENTRIES + 1) + 1;
  localparam int unsigned PSW = FRAC_BITS + IXW;
  localparam int unsigned EW  = FRAC_BITS + 5;
  localparam int unsigned DW  = FRAC_BITS + 7;

  localparam logic [FRAC_BITS:0]   ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0]   HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  localparam logic [EW-1:0] B4  = EW'(4) << FRAC_BITS;
  localparam logic [EW-1:0] B8  = EW'(8) << FRAC_BITS;
  localparam logic [EW-1:0] B10 = EW'(10) << FRAC_BITS;
  localparam logic signed [DW-1:0] K6  = DW'(6) << FRAC_BITS;
  localparam logic signed [DW-1:0] K9  = DW'(9) << FRAC_BITS;
  localparam logic signed [DW-1:0] K21 = DW'(21) << FRAC_BITS;

  // stage A
  logic                 vld_a_q;
  logic [OP_W-1:0]      op_a_q;
  logic [FRAC_BITS:0]   prog_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_a_q   <= op_i;
    prog_a_q <= progress_i;
  end

  logic [FRAC_BITS:0]   t;
  logic [FRAC_BITS:0]   u;
  logic                 lower;
  logic [FRAC_BITS+1:0] t2;
  logic [FRAC_BITS+1:0] dn;
  logic [FRAC_BITS+1:0] up;
  ctl_t                 ctl_b_d;
  logic [FRAC_BITS:0]   x_b_d;

  always_comb begin
    t     = (prog_a_q > ONE) ? ONE : prog_a_q;
    u     = ONE - t;
    lower = (t < HALF);
    t2    = {t, 1'b0};
    dn    = {1'b0, ONE} - t2;
    up    = t2 - {1'b0, ONE};

    ctl_b_d = '{kind: KIND_LINEAR, cubic: 1'b0, add_one: 1'b0, negate: 1'b0,
                shl: 2'd0, halve: 1'b0};
    x_b_d   = t;

    unique case (op_e'(op_a_q)) inside
      OP_IN, OP_QUAD_IN: begin
        ctl_b_d.kind = KIND_POLY;
      end
      OP_OUT, OP_QUAD_OUT: begin
        ctl_b_d.kind    = KIND_POLY;
        ctl_b_d.add_one = 1'b1;
        ctl_b_d.negate  = 1'b1;
        x_b_d           = u;
      end
      OP_INOUT, OP_QUAD_INOUT: begin
        ctl_b_d.kind = KIND_POLY;
        ctl_b_d.shl  = 2'd1;
        if (!lower) begin
          ctl_b_d.add_one = 1'b1;
          ctl_b_d.negate  = 1'b1;
          x_b_d           = u;
        end
      end
      OP_CUBIC_IN: begin
        ctl_b_d.kind  = KIND_POLY;
        ctl_b_d.cubic = 1'b1;
      end
      OP_CUBIC_OUT: begin
        ctl_b_d.kind    = KIND_POLY;
        ctl_b_d.cubic   = 1'b1;
        ctl_b_d.add_one = 1'b1;
        ctl_b_d.negate  = 1'b1;
        x_b_d           = u;
      end
      OP_CUBIC_INOUT: begin
        ctl_b_d.kind  = KIND_POLY;
        ctl_b_d.cubic = 1'b1;
        ctl_b_d.shl   = 2'd2;
        if (!lower) begin
          ctl_b_d.add_one = 1'b1;
          ctl_b_d.negate  = 1'b1;
          x_b_d           = u;
        end
      end
      OP_SINE_IN, OP_BOUNCE_IN: begin
        ctl_b_d.kind    = (op_e'(op_a_q) == OP_SINE_IN) ? KIND_SINE : KIND_BOUNCE;
        ctl_b_d.add_one = 1'b1;
        ctl_b_d.negate  = 1'b1;
        x_b_d           = u;
      end
      OP_SINE_OUT, OP_BOUNCE_OUT: begin
        ctl_b_d.kind = (op_e'(op_a_q) == OP_SINE_OUT) ? KIND_SINE : KIND_BOUNCE;
      end
      OP_SINE_INOUT, OP_BOUNCE_INOUT: begin
        ctl_b_d.kind    = (op_e'(op_a_q) == OP_SINE_INOUT) ? KIND_SINE : KIND_BOUNCE;
        ctl_b_d.add_one = 1'b1;
        ctl_b_d.halve   = 1'b1;
        if (lower) begin
          ctl_b_d.negate = 1'b1;
          x_b_d          = dn[FRAC_BITS:0];
        end else begin
          x_b_d          = up[FRAC_BITS:0];
        end
      end
      default: begin
        ctl_b_d.kind = KIND_LINEAR;
      end
    endcase
  end

  // stage B
  logic               vld_b_q;
  ctl_t               ctl_b_q;
  logic [FRAC_BITS:0] x_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_b_q <= ctl_b_d;
    x_b_q   <= x_b_d;
  end

  logic [PSW-1:0]        p;
  logic [IXW-1:0]        idx;
  logic [IXW-1:0]        ea;
  logic [IXW-1:0]        oa;
  logic [EW-1:0]         e;
  logic signed [DW-1:0]  e_s;
  logic signed [DW-1:0]  d_s;
  logic [DW-1:0]         d_abs;

  always_comb begin
    p   = PSW'(x_b_q) * PSW'(SINE_ENTRIES);
    idx = p[PSW-1:FRAC_BITS];
    ea  = (idx + IXW'(1)) >> 1;
    oa  = idx >> 1;
    if (ea > IXW'(NE - 1)) begin
      ea = IXW'(NE - 1);
    end
    if (oa > IXW'(NO - 1)) begin
      oa = IXW'(NO - 1);
    end
    // top of the quarter wave reads the last entry alone
    frac_o      = (idx == IXW'(SINE_ENTRIES)) ? '0 : p[FRAC_BITS-1:0];
    odd_lo_o    = idx[0];
    even_addr_o = ea[EAW-1:0];
    odd_addr_o  = oa[OAW-1:0];

    e   = EW'(x_b_q) * EW'(11);
    e_s = $signed({2'b00, e});
    if (e < B4) begin
      seg_o = SEG_0;
      d_s   = e_s;
    end else if (e < B8) begin
      seg_o = SEG_1;
      d_s   = e_s - K6;
    end else if (e < B10) begin
      seg_o = SEG_2;
      d_s   = e_s - K9;
    end else begin
      seg_o = SEG_3;
      d_s   = (e_s <<< 1) - K21;
    end
    d_abs  = (d_s < 0) ? DW'(-d_s) : DW'(d_s);
    dabs_o = d_abs[FRAC_BITS+1:0];
  end

  assign valid_o = vld_b_q;
  assign ctl_o   = ctl_b_q;
  assign x_o     = x_b_q;

endmodule

// ----- hdl/ecev_sine_rom.sv -----
// ----------------------------------------------------------------------------
// ecev_sine_rom
// Quarter-wave sine table split into even and odd banks, registered read,
// so an entry and its neighbor come out in the same cycle.
// ----------------------------------------------------------------------------
module ecev_sine_rom #(
  parameter int unsigned FRAC_BITS    = ecev_pkg::FRAC_BITS_DEFAULT,
  parameter int unsigned SINE_ENTRIES = ecev_pkg::SINE_ENTRIES_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic [$clog2(SINE_ENTRIES/2+1)-1:0]    even_addr_i,
  input  logic [$clog2((SINE_ENTRIES+1)/2)-1:0]  odd_addr_i,
  output logic [FRAC_BITS:0]                     even_data_o,
  output logic [FRAC_BITS:0]                     odd_data_o
);
  import ecev_pkg::*;

  localparam int unsigned NE = SINE_ENTRIES / 2 + 1;
  localparam int unsigned NO = (SINE_ENTRIES + 1) / 2;

  logic [FRAC_BITS:0] even_rom [NE];
  logic [FRAC_BITS:0] odd_rom  [NO];

  for (genvar k = 0; k < NE; k++) begin : g_even
    localparam logic [63:0] ANG = (PIHALF_Q30 * 64'(2 * k) + 64'(SINE_ENTRIES / 2))
                                  / 64'(SINE_ENTRIES);
    localparam logic [63:0] VAL = sine_entry(ANG, FRAC_BITS);
    assign even_rom[k] = VAL[FRAC_BITS:0];
  end

  for (genvar k = 0; k < NO; k++) begin : g_odd
    localparam logic [63:0] ANG = (PIHALF_Q30 * 64'(2 * k + 1) + 64'(SINE_ENTRIES / 2))
                                  / 64'(SINE_ENTRIES);
    localparam logic [63:0] VAL = sine_entry(ANG, FRAC_BITS);
    assign odd_rom[k] = VAL[FRAC_BITS:0];
  end

  always_ff @(posedge clk_i) begin
    even_data_o <= even_rom[even_addr_i];
    odd_data_o  <= odd_rom[odd_addr_i];
  end

endmodule

// ----- hdl/ecev_arith.sv -----
// ----------------------------------------------------------------------------
// ecev_arith
// Shared squaring/interpolation multiplier, rounding, cube multiplier and
// final combine with clamp. Five register stages including the output.
// ----------------------------------------------------------------------------
module ecev_arith #(
  parameter int unsigned FRAC_BITS = ecev_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ecev_pkg::ctl_t         ctl_i,
  input  logic [FRAC_BITS:0]     x_i,
  input  logic [FRAC_BITS-1:0]   frac_i,
  input  logic                   odd_lo_i,
  input  logic [FRAC_BITS+1:0]   dabs_i,
  input  ecev_pkg::seg_e         seg_i,
  input  logic [FRAC_BITS:0]     even_data_i,
  input  logic [FRAC_BITS:0]     odd_data_i,
  output logic                   valid_o,
  output logic [FRAC_BITS:0]     eased_o
);
  import ecev_pkg::*;

  localparam int unsigned W1 = FRAC_BITS + 1;
  localparam int unsigned W  = FRAC_BITS + 2;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned QW = 2 * W1;
  localparam int unsigned SW = FRAC_BITS + 5;

  localparam logic [FRAC_BITS:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] C3_4  = W1'(3) << (FRAC_BITS - 2);
  localparam logic [FRAC_BITS:0] C15_16 = W1'(15) << (FRAC_BITS - 4);
  localparam logic [FRAC_BITS:0] C63_64 = W1'(63) << (FRAC_BITS - 6);
  localparam logic [PW:0] RND_F = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] RND_4 = (PW+1)'(1) << (FRAC_BITS + 3);
  localparam logic [PW:0] RND_6 = (PW+1)'(1) << (FRAC_BITS + 5);
  localparam logic [QW:0] RND_Q = (QW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  // stage C
  logic                 vld_c_q;
  ctl_t                 ctl_c_q;
  logic [FRAC_BITS:0]   x_c_q;
  logic [FRAC_BITS-1:0] frac_c_q;
  logic                 odd_c_q;
  logic [W-1:0]         dabs_c_q;
  seg_e                 seg_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_c_q  <= ctl_i;
    x_c_q    <= x_i;
    frac_c_q <= frac_i;
    odd_c_q  <= odd_lo_i;
    dabs_c_q <= dabs_i;
    seg_c_q  <= seg_i;
  end

  logic [FRAC_BITS:0] lo;
  logic [FRAC_BITS:0] hi;
  logic [FRAC_BITS:0] diff;
  logic [W-1:0]       ma;
  logic [W-1:0]       mb;
  logic [FRAC_BITS:0] addc_d;
  logic [PW-1:0]      prod_d;

  always_comb begin
    lo   = odd_c_q ? odd_data_i : even_data_i;
    hi   = odd_c_q ? even_data_i : odd_data_i;
    diff = (hi > lo) ? (hi - lo) : '0;
    case (ctl_c_q.kind)
      KIND_SINE: begin
        ma     = W'(diff);
        mb     = W'(frac_c_q);
        addc_d = lo;
      end
      KIND_BOUNCE: begin
        ma = dabs_c_q;
        mb = dabs_c_q;
        case (seg_c_q)
          SEG_1:   addc_d = C3_4;
          SEG_2:   addc_d = C15_16;
          SEG_3:   addc_d = C63_64;
          default: addc_d = '0;
        endcase
      end
      default: begin
        ma     = W'(x_c_q);
        mb     = W'(x_c_q);
        addc_d = '0;
      end
    endcase
    prod_d = ma * mb;
  end

  // stage D
  logic               vld_d_q;
  ctl_t               ctl_d_q;
  logic [FRAC_BITS:0] x_d_q;
  seg_e               seg_d_q;
  logic [PW-1:0]      prod_q;
  logic [FRAC_BITS:0] addc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_d_q <= ctl_c_q;
    x_d_q   <= x_c_q;
    seg_d_q <= seg_c_q;
    prod_q  <= prod_d;
    addc_q  <= addc_d;
  end

  logic [PW:0]        r_f;
  logic [PW:0]        r_4;
  logic [PW:0]        r_6;
  logic [W-1:0]       rnd;
  logic [W:0]         vsum;
  logic [FRAC_BITS:0] v1_d;

  always_comb begin
    r_f = ({1'b0, prod_q} + RND_F) >> FRAC_BITS;
    r_4 = ({1'b0, prod_q} + RND_4) >> (FRAC_BITS + 4);
    r_6 = ({1'b0, prod_q} + RND_6) >> (FRAC_BITS + 6);
    if (ctl_d_q.kind == KIND_BOUNCE) begin
      rnd = (seg_d_q == SEG_3) ? r_6[W-1:0] : r_4[W-1:0];
    end else begin
      rnd = r_f[W-1:0];
    end
    vsum = (W+1)'(rnd) + (W+1)'(addc_q);
    if (ctl_d_q.kind == KIND_LINEAR) begin
      v1_d = x_d_q;
    end else if (vsum > (W+1)'(ONE)) begin
      v1_d = ONE;
    end else begin
      v1_d = vsum[FRAC_BITS:0];
    end
  end

  // stage E
  logic               vld_e_q;
  ctl_t               ctl_e_q;
  logic [FRAC_BITS:0] x_e_q;
  logic [FRAC_BITS:0] v1_e_q;
  logic [QW-1:0]      prod2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_e_q <= ctl_d_q;
    x_e_q   <= x_d_q;
    v1_e_q  <= v1_d;
  end

  assign prod2_d = v1_e_q * x_e_q;

  // stage F
  logic               vld_f_q;
  ctl_t               ctl_f_q;
  logic [FRAC_BITS:0] v1_f_q;
  logic [QW-1:0]      prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else begin
      vld_f_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_f_q <= ctl_e_q;
    v1_f_q  <= v1_e_q;
    prod2_q <= prod2_d;
  end

  logic [QW:0]          r_q;
  logic [FRAC_BITS:0]   v;
  logic signed [SW-1:0] vs;
  logic signed [SW-1:0] term;
  logic signed [SW-1:0] r;
  logic [FRAC_BITS:0]   eased_d;

  always_comb begin
    r_q  = ({1'b0, prod2_q} + RND_Q) >> FRAC_BITS;
    v    = ctl_f_q.cubic ? r_q[FRAC_BITS:0] : v1_f_q;
    vs   = $signed({4'b0000, v}) <<< ctl_f_q.shl;
    term = ctl_f_q.negate ? -vs : vs;
    r    = (ctl_f_q.add_one ? ONE_S : '0) + term;
    if (ctl_f_q.halve) begin
      r = (r + SW'(1)) >>> 1;
    end
    if (r < 0) begin
      eased_d = '0;
    end else if (r > ONE_S) begin
      eased_d = ONE;
    end else begin
      eased_d = r[FRAC_BITS:0];
    end
  end

  // output register
  logic               done_q;
  logic [FRAC_BITS:0] eased_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eased_q <= eased_d;
  end

  assign valid_o = done_q;
  assign eased_o = eased_q;

endmodule

// ----- hdl/ecev_checker.sv -----
// ----------------------------------------------------------------------------
// ecev_checker
// Port-level checks on the easing evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module ecev_checker #(
  parameter int unsigned FRAC_BITS = ecev_pkg::FRAC_BITS_DEFAULT
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [ecev_pkg::OP_W-1:0]  op_i,
  input logic [FRAC_BITS:0]         progress_i,
  input logic                       done_o,
  input logic [FRAC_BITS:0]         eased_o
);
  import ecev_pkg::*;

  localparam int unsigned LATENCY = 7;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  a_result_follows_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("item without result");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without item");

  a_result_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (eased_o <= ONE))
    else $error("result above one");

  a_linear_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_LINEAR && progress_i <= ONE)
      |-> ##LATENCY (eased_o == $past(progress_i, LATENCY)))
    else $error("linear curve mismatch");

endmodule

bind easing_curve_evaluator ecev_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_ecev_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .op_i       (op_i),
  .progress_i (progress_i),
  .done_o     (done_o),
  .eased_o    (eased_o)
);
